### hw/rtl/itc_pkg.sv
// shared types and constants for the interval timer channel
`timescale 1ns / 1ps
`default_nettype none

package itc_pkg;

    // function codes of one beat
    localparam logic [1:0] FUNC_CMD  = 2'd0;
    localparam logic [1:0] FUNC_DATA = 2'd1;
    localparam logic [1:0] FUNC_CLK  = 2'd2;

    // control word field masks
    localparam logic [7:0] CW_MODE_MASK = 8'b0000_0111;
    localparam logic [7:0] CW_ACC_MASK  = 8'b0000_0011;

    // access modes
    localparam logic [1:0] ACC_LATCH    = 2'd0;
    localparam logic [1:0] ACC_LSB_ONLY = 2'd1;
    localparam logic [1:0] ACC_MSB_ONLY = 2'd2;
    localparam logic [1:0] ACC_LSB_MSB  = 2'd3;

    // counter select of channel 0
    localparam logic [1:0] SEL_CH0 = 2'd0;

    // count modes
    localparam logic [2:0] MODE_INT_TC   = 3'd0;
    localparam logic [2:0] MODE_RATE_GEN = 3'd2;

    localparam int COUNT_W  = 16;
    localparam int RESULT_TICK_W = 32;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] wdata;
    } itc_req_t;

    typedef struct packed {
        logic                     irq_pulse;
        logic                     out_level;
        logic [COUNT_W-1:0]       count_now;
        logic [RESULT_TICK_W-1:0] tick_total;
    } itc_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/itc_core.sv
// timer channel state and the single-pass next-state and result logic
`timescale 1ns / 1ps
`default_nettype none

module itc_core #(
    parameter int TICK_COUNT_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire itc_pkg::itc_req_t req,
    output itc_pkg::itc_rsp_t     rsp
);
    import itc_pkg::*;

    logic [2:0]                  count_mode_reg, count_mode_next;
    logic [1:0]                  access_mode_reg, access_mode_next;
    logic                        expect_high_reg, expect_high_next;
    logic [7:0]                  low_hold_reg, low_hold_next;
    logic [COUNT_W-1:0]          reload_reg, reload_next;
    logic [COUNT_W-1:0]          ce_reg, ce_next;
    logic                        pending_reg, pending_next;
    logic                        running_reg, running_next;
    logic                        pin_reg, pin_next;
    logic [TICK_COUNT_WIDTH-1:0] tick_reg, tick_next;

    logic [1:0]         cw_sel;
    logic [1:0]         cw_acc;
    logic [2:0]         cw_mode;
    logic               written;
    logic [COUNT_W-1:0] ce_dec;
    logic               rose;
    logic [63:0]        tick_wide;

    assign cw_sel  = req.wdata[7:6];
    assign cw_acc  = 2'(req.wdata >> 4) & CW_ACC_MASK[1:0];
    assign cw_mode = 3'(req.wdata >> 1) & CW_MODE_MASK[2:0];
    assign ce_dec  = ce_reg - COUNT_W'(1);

    always_comb
    begin
        count_mode_next  = count_mode_reg;
        access_mode_next = access_mode_reg;
        expect_high_next = expect_high_reg;
        low_hold_next    = low_hold_reg;
        reload_next      = reload_reg;
        ce_next          = ce_reg;
        pending_next     = pending_reg;
        running_next     = running_reg;
        pin_next         = pin_reg;
        written          = 1'b0;

        unique case (req.func)
            FUNC_CMD:
            begin
                if (cw_sel == SEL_CH0 && cw_acc != ACC_LATCH)
                begin
                    access_mode_next = cw_acc;
                    count_mode_next  = cw_mode;
                    expect_high_next = 1'b0;
                    running_next     = 1'b0;
                    pending_next     = 1'b0;
                    pin_next         = (cw_mode != MODE_INT_TC);
                end
            end
            FUNC_DATA:
            begin
                priority if (access_mode_reg == ACC_LSB_ONLY)
                begin
                    reload_next = {8'h00, req.wdata};
                    written     = 1'b1;
                end
                else if (access_mode_reg == ACC_MSB_ONLY)
                begin
                    reload_next = {req.wdata, 8'h00};
                    written     = 1'b1;
                end
                else if (!expect_high_reg)
                begin
                    low_hold_next    = req.wdata;
                    expect_high_next = 1'b1;
                    if (count_mode_reg == MODE_INT_TC)
                    begin
                        running_next = 1'b0;
                    end
                end
                else
                begin
                    reload_next      = {req.wdata, low_hold_reg};
                    expect_high_next = 1'b0;
                    written          = 1'b1;
                end

                if (written)
                begin
                    if (count_mode_reg == MODE_INT_TC)
                    begin
                        pin_next     = 1'b0;
                        running_next = 1'b0;
                        pending_next = 1'b1;
                    end
                    else if (count_mode_reg == MODE_RATE_GEN && !running_reg)
                    begin
                        pending_next = 1'b1;
                    end
                end
            end
            FUNC_CLK:
            begin
                if (count_mode_reg == MODE_INT_TC || count_mode_reg == MODE_RATE_GEN)
                begin
                    priority if (pending_reg)
                    begin
                        ce_next      = reload_reg;
                        pending_next = 1'b0;
                        running_next = 1'b1;
                    end
                    else if (running_reg)
                    begin
                        if (count_mode_reg == MODE_INT_TC)
                        begin
                            ce_next = ce_dec;
                            if (ce_dec == '0)
                            begin
                                pin_next = 1'b1;
                            end
                        end
                        else
                        begin
                            priority if (!pin_reg)
                            begin
                                pin_next = 1'b1;
                                ce_next  = reload_reg;
                            end
                            else if (ce_reg == COUNT_W'(1))
                            begin
                                pin_next = 1'b0;
                            end
                            else
                            begin
                                ce_next = ce_dec;
                                if (ce_dec == COUNT_W'(1))
                                begin
                                    pin_next = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rose      = !pin_reg && pin_next;
    assign tick_next = tick_reg + TICK_COUNT_WIDTH'(rose);
    assign tick_wide = 64'(tick_next);

    assign rsp.irq_pulse  = rose;
    assign rsp.out_level  = pin_next;
    assign rsp.count_now  = ce_next;
    assign rsp.tick_total = tick_wide[RESULT_TICK_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg  <= MODE_INT_TC;
            access_mode_reg <= ACC_LSB_MSB;
            expect_high_reg <= 1'b0;
            low_hold_reg    <= '0;
            reload_reg      <= '0;
            ce_reg          <= '0;
            pending_reg     <= 1'b0;
            running_reg     <= 1'b0;
            pin_reg         <= 1'b1;
            tick_reg        <= '0;
        end
        else if (en)
        begin
            count_mode_reg  <= count_mode_next;
            access_mode_reg <= access_mode_next;
            expect_high_reg <= expect_high_next;
            low_hold_reg    <= low_hold_next;
            reload_reg      <= reload_next;
            ce_reg          <= ce_next;
            pending_reg     <= pending_next;
            running_reg     <= running_next;
            pin_reg         <= pin_next;
            tick_reg        <= tick_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/interval_timer_channel_unit.sv
// top level of the interval timer channel: beat registers around the timer core
//
// usage
//   req channel (req_valid/req_ready/req): one beat per command-port write,
//   data-port write or input clock pulse, selected by req.func
//   rsp channel (rsp_valid/rsp_ready/rsp): one beat per request beat, in order,
//   carrying the interrupt edge, output level, counting element and tick total
//   throughput: one beat per cycle while rsp_ready stays high, set by the
//   single-pass next-state logic of the core between the request register and
//   the response register
//   stall: while rsp is held, the request register still takes one more beat;
//   req_ready drops only when both registers are full and rsp_ready is low
//   reset: both registers empty, timer stopped with output high, access mode
//   low then high byte, tick total zero
//
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_channel_unit #(
    parameter int TICK_COUNT_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire itc_pkg::itc_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output itc_pkg::itc_rsp_t      rsp
);
    import itc_pkg::*;

    logic     in_vld_reg;
    itc_req_t in_data_reg;
    logic     out_vld_reg;
    itc_rsp_t out_data_reg;
    itc_rsp_t core_rsp;
    logic     advance;

    assign advance   = in_vld_reg && (!out_vld_reg || rsp_ready);
    assign req_ready = !in_vld_reg || advance;
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_data_reg;

    itc_core #(
        .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
    ) u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (advance),
        .req  (in_data_reg),
        .rsp  (core_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_vld_reg <= req_valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_data_reg <= req;
        end
        if (advance)
        begin
            out_data_reg <= core_rsp;
        end
    end

    // an interrupt edge always leaves the output high
    a_irq_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_data_reg.irq_pulse |-> out_data_reg.out_level)
        else $error("irq beat with output low");

    // back-pressure only when both beat registers are full and held
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> in_vld_reg && out_vld_reg && !rsp_ready)
        else $error("request stalled without a full pipeline");

    // a beat leaving the request register lands in the response register
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("advanced beat lost");

endmodule

`default_nettype wire

### verif/tb_interval_timer_channel_unit.sv
// self-checking testbench for the interval timer channel unit
`timescale 1ns / 1ps

module tb_interval_timer_channel_unit;

    import itc_pkg::*;

    localparam logic [1:0] FUNC_SPARE   = 2'd3;
    localparam logic [1:0] SEL_READBACK = 2'd3;
    localparam logic [2:0] MODE_SQUARE  = 3'd3;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    itc_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    itc_rsp_t rsp;

    logic     req_taken = 1'b0;
    int       idle_pct  = 0;
    int       stall_pct = 0;
    int       beats_queued = 0;
    int       mismatch_count = 0;

    itc_req_t beat_backlog[$];
    itc_rsp_t timer_expected[$];

    // predicted timer state
    logic [2:0]  pit_mode;
    logic [1:0]  pit_access;
    logic        pit_hi_next;
    logic [7:0]  pit_lo_hold;
    logic [15:0] pit_reload;
    logic [15:0] pit_element;
    logic        pit_load_wait;
    logic        pit_run;
    logic        pit_pin;
    logic [31:0] pit_ticks;

    interval_timer_channel_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic void count_complete();
        if (pit_mode == MODE_INT_TC)
        begin
            pit_pin       = 1'b0;
            pit_run       = 1'b0;
            pit_load_wait = 1'b1;
        end
        else if (pit_mode == MODE_RATE_GEN && !pit_run)
        begin
            pit_load_wait = 1'b1;
        end
    endfunction

    function automatic itc_rsp_t timer_next(input itc_req_t beat);
        itc_rsp_t res;
        logic     was_high;
        logic     rose;
        was_high = pit_pin;
        case (beat.func)
            FUNC_CMD:
            begin
                if (beat.wdata[7:6] == SEL_CH0 && beat.wdata[5:4] != ACC_LATCH)
                begin
                    pit_access    = beat.wdata[5:4];
                    pit_mode      = beat.wdata[3:1];
                    pit_hi_next   = 1'b0;
                    pit_run       = 1'b0;
                    pit_load_wait = 1'b0;
                    pit_pin       = (pit_mode != MODE_INT_TC);
                end
            end
            FUNC_DATA:
            begin
                if (pit_access == ACC_LSB_ONLY)
                begin
                    pit_reload = {8'h00, beat.wdata};
                    count_complete();
                end
                else if (pit_access == ACC_MSB_ONLY)
                begin
                    pit_reload = {beat.wdata, 8'h00};
                    count_complete();
                end
                else if (!pit_hi_next)
                begin
                    pit_lo_hold = beat.wdata;
                    pit_hi_next = 1'b1;
                    if (pit_mode == MODE_INT_TC)
                        pit_run = 1'b0;
                end
                else
                begin
                    pit_reload  = {beat.wdata, pit_lo_hold};
                    pit_hi_next = 1'b0;
                    count_complete();
                end
            end
            FUNC_CLK:
            begin
                if (pit_mode == MODE_INT_TC || pit_mode == MODE_RATE_GEN)
                begin
                    if (pit_load_wait)
                    begin
                        pit_element   = pit_reload;
                        pit_load_wait = 1'b0;
                        pit_run       = 1'b1;
                    end
                    else if (pit_run && pit_mode == MODE_INT_TC)
                    begin
                        pit_element = pit_element - 16'd1;
                        if (pit_element == '0)
                            pit_pin = 1'b1;
                    end
                    else if (pit_run)
                    begin
                        if (!pit_pin)
                        begin
                            pit_pin     = 1'b1;
                            pit_element = pit_reload;
                        end
                        else if (pit_element == 16'd1)
                        begin
                            pit_pin = 1'b0;
                        end
                        else
                        begin
                            pit_element = pit_element - 16'd1;
                            if (pit_element == 16'd1)
                                pit_pin = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        rose = !was_high && pit_pin;
        if (rose)
            pit_ticks = pit_ticks + 32'd1;
        res.irq_pulse  = rose;
        res.out_level  = pit_pin;
        res.count_now  = pit_element;
        res.tick_total = pit_ticks;
        return res;
    endfunction

    function automatic logic [7:0] ctrl_word(input logic [1:0] sel, input logic [1:0] acc,
                                             input logic [2:0] mode, input logic bcd);
        return {sel, acc, mode, bcd};
    endfunction

    task automatic queue_beat(input logic [1:0] f, input logic [7:0] d);
        itc_req_t beat;
        beat.func  = f;
        beat.wdata = d;
        beat_backlog.push_back(beat);
        beats_queued++;
    endtask

    task automatic queue_count(input logic [1:0] acc, input logic [15:0] cnt);
        if (acc != ACC_MSB_ONLY)
            queue_beat(FUNC_DATA, cnt[7:0]);
        if (acc != ACC_LSB_ONLY)
            queue_beat(FUNC_DATA, cnt[15:8]);
    endtask

    task automatic queue_clocks(input int n);
        repeat (n)
            queue_beat(FUNC_CLK, 8'($urandom_range(255)));
    endtask

    task automatic fill_random(input int n);
        int          target;
        int          span;
        logic [1:0]  acc;
        logic [2:0]  mode;
        logic [15:0] cnt;
        target = beats_queued + n;
        while (beats_queued < target)
        begin
            if ($urandom_range(99) < 85)
            begin
                acc = 2'($urandom_range(ACC_LSB_MSB, ACC_LSB_ONLY));
                if ($urandom_range(99) < 80)
                    mode = $urandom_range(1) ? MODE_RATE_GEN : MODE_INT_TC;
                else
                    mode = 3'($urandom_range(7));
                queue_beat(FUNC_CMD, ctrl_word(SEL_CH0, acc, mode, 1'($urandom_range(1))));
                repeat ($urandom_range(3, 1))
                begin
                    case ($urandom_range(19))
                        0: cnt = '0;
                        1, 2: cnt = 16'($urandom_range(16'hFFFF));
                        default: cnt = 16'($urandom_range(12, 1));
                    endcase
                    if (acc == ACC_LSB_ONLY)
                        cnt[15:8] = '0;
                    else if (acc == ACC_MSB_ONLY)
                        cnt[7:0] = '0;
                    // broken two-byte write
                    if (acc == ACC_LSB_MSB && $urandom_range(9) == 0)
                        queue_beat(FUNC_DATA, cnt[7:0]);
                    else
                        queue_count(acc, cnt);
                    span = (cnt != '0 && cnt < 16'd16) ? 3 * cnt + 4 : 30;
                    queue_clocks($urandom_range(span, 1));
                    if ($urandom_range(9) == 0)
                        queue_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    queue_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int n);
        idle_pct  = idle;
        stall_pct = stall;
        fill_random(n);
        while (beat_backlog.size() != 0 || req_valid || timer_expected.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (beat_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    req_valid <= 1'b1;
                    req       <= beat_backlog.pop_front();
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
            rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        itc_rsp_t want;
        if (rst_n)
        begin
            req_taken <= req_valid && req_ready;
            if (rsp_valid && rsp_ready)
            begin
                if (timer_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: irq %0b lvl %0b cnt %h ticks %0d",
                                 rsp.irq_pulse, rsp.out_level, rsp.count_now, rsp.tick_total);
                end
                else
                begin
                    want = timer_expected.pop_front();
                    if (rsp.irq_pulse !== want.irq_pulse || rsp.out_level !== want.out_level
                        || rsp.count_now !== want.count_now
                        || rsp.tick_total !== want.tick_total)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp irq %0b lvl %0b cnt %h ticks %0d,",
                                     want.irq_pulse, want.out_level, want.count_now,
                                     want.tick_total,
                                     " got irq %0b lvl %0b cnt %h ticks %0d",
                                     rsp.irq_pulse, rsp.out_level,
                                     rsp.count_now, rsp.tick_total);
                    end
                end
            end
            if (req_valid && req_ready)
                timer_expected.push_back(timer_next(req));
        end
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        pit_mode      = MODE_INT_TC;
        pit_access    = ACC_LSB_MSB;
        pit_hi_next   = 1'b0;
        pit_lo_hold   = '0;
        pit_reload    = '0;
        pit_element   = '0;
        pit_load_wait = 1'b0;
        pit_run       = 1'b0;
        pit_pin       = 1'b1;
        pit_ticks     = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // unused function code, ignored control words
        queue_beat(FUNC_SPARE, 8'hFF);
        queue_beat(FUNC_CMD, ctrl_word(SEL_READBACK, ACC_LSB_MSB, MODE_RATE_GEN, 1'b0));
        queue_beat(FUNC_CMD, ctrl_word(SEL_CH0, ACC_LATCH, MODE_RATE_GEN, 1'b0));
        // mode 0 to terminal count and wrap
        queue_beat(FUNC_CMD, ctrl_word(SEL_CH0, ACC_LSB_ONLY, MODE_INT_TC, 1'b0));
        queue_count(ACC_LSB_ONLY, 16'd2);
        queue_clocks(4);
        // mode 0 first byte halts counting
        queue_beat(FUNC_CMD, ctrl_word(SEL_CH0, ACC_LSB_MSB, MODE_INT_TC, 1'b0));
        queue_count(ACC_LSB_MSB, 16'hFFFF);
        queue_clocks(1);
        queue_beat(FUNC_DATA, 8'h01);
        queue_clocks(1);
        // rate generator, count of zero
        queue_beat(FUNC_CMD, ctrl_word(SEL_CH0, ACC_MSB_ONLY, MODE_RATE_GEN, 1'b1));
        queue_count(ACC_MSB_ONLY, 16'h0000);
        queue_clocks(2);
        // rate generator, count of one then a later count
        queue_beat(FUNC_CMD, ctrl_word(SEL_CH0, ACC_LSB_MSB, MODE_RATE_GEN, 1'b0));
        queue_count(ACC_LSB_MSB, 16'd1);
        queue_clocks(3);
        queue_count(ACC_LSB_MSB, 16'd3);
        queue_clocks(2);
        // stopped mode
        queue_beat(FUNC_CMD, ctrl_word(SEL_CH0, ACC_LSB_ONLY, MODE_SQUARE, 1'b0));
        queue_count(ACC_LSB_ONLY, 16'd5);
        queue_clocks(1);

        run_phase(0, 0, 330);
        run_phase(67, 0, 330);
        run_phase(0, 67, 330);
        run_phase(36, 36, 330);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && timer_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
